>>> rtl/mfg_pkg.sv
package mfg_pkg;

    localparam int PIX_W    = 8;
    localparam int CFG_W_W  = 11;
    localparam int CFG_H_W  = 12;
    localparam int CFG_K_W  = 3;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    typedef logic [PIX_W-1:0]   t_pix;
    typedef logic [CFG_W_W-1:0] t_cfg_w;
    typedef logic [CFG_H_W-1:0] t_cfg_h;
    typedef logic [CFG_K_W-1:0] t_cfg_k;
    typedef logic [1:0]         t_reg_idx;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    localparam t_reg_idx REG_WIDTH  = 2'd0;
    localparam t_reg_idx REG_HEIGHT = 2'd1;
    localparam t_reg_idx REG_KERNEL = 2'd2;

    localparam t_cfg_w RST_WIDTH  = 11'd640;
    localparam t_cfg_h RST_HEIGHT = 12'd480;
    localparam t_cfg_k RST_KERNEL = 3'd3;

endpackage

>>> rtl/mfg_in_if.sv
interface mfg_in_if import mfg_pkg::*; ();
    logic valid;
    logic ready;
    logic req_type;
    t_pix pixel_value;

    modport source (output valid, output req_type, output pixel_value, input ready);
    modport sink (input valid, input req_type, input pixel_value, output ready);
endinterface

>>> rtl/mfg_out_if.sv
interface mfg_out_if import mfg_pkg::*; ();
    logic valid;
    logic ready;
    t_pix out_value;
    logic frame_last;

    modport source (output valid, output out_value, output frame_last, input ready);
    modport sink (input valid, input out_value, input frame_last, output ready);
endinterface

>>> rtl/mfg_median.sv
module mfg_median import mfg_pkg::*; #(
    parameter int NUM  = 49,
    parameter int MIDW = 6
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [NUM-1:0][PIX_W-1:0]  i_vals,
    input  logic [NUM-1:0]             i_mask,
    input  logic [MIDW-1:0]            i_mid,
    output t_pix                       o_med
);

    logic [NUM-1:0][PIX_W-1:0] r_val;
    logic [NUM-1:0]            r_mask;
    logic [NUM-1:0][NUM-1:0]   r_lt;

    // rank matrix: j sorts ahead of i, ties broken by index
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NUM; i++) begin
                for (int j = 0; j < NUM; j++) begin
                    r_lt[i][j] <= i_mask[j] && ((i_vals[j] < i_vals[i]) ||
                                  ((i_vals[j] == i_vals[i]) && (j < i)));
                end
            end
            r_val  <= i_vals;
            r_mask <= i_mask;
        end
    end

    always_comb begin
        o_med = '0;
        for (int i = 0; i < NUM; i++) begin
            if (r_mask[i] && (MIDW'($countones(r_lt[i])) == i_mid)) begin
                o_med = o_med | r_val[i];
            end
        end
    end

endmodule

>>> rtl/median_filter_gray.sv
// median_filter_gray: streaming k-by-k median filter for 8-bit gray frames
//
// i_in carries raster pixels (req_type pixel) or flush ticks; o_out carries
// filtered pixels with frame_last on the final pixel of the frame. a transfer
// happens when valid and ready are both high. the APB port sets width, height
// and kernel size; a write to any of these registers restarts the frame counters.
//
// a result passes through stages s1, s2, s3 and the output register to o_out.
// in raster terms the output lags the input by (k/2)*width + k/2 pixels; after
// the last pixel of a frame, that many flush ticks drain the rest. throughput
// is one transfer per cycle unless o_out stalls: the line store is a single
// memory, one column word of all line buffers wide, with a lane write and two
// reads per cycle, and the median is a registered rank matrix over the window.
//
// reset clears the counters and pipeline valids and loads 640x480, k=3; the
// line store needs no clearing since only pixels of the current frame are read.
// when o_out stalls, the whole pipeline holds and i_in.ready drops with it.
module median_filter_gray import mfg_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    mfg_in_if.sink            i_in,
    mfg_out_if.source         o_out
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int WEW    = CW + 1;
    localparam int LB     = $clog2(MAX_KERNEL);
    localparam int KCAP   = (MAX_KERNEL > 7) ? 7 : MAX_KERNEL;
    localparam int LAGMAX = (KCAP / 2) * MAX_WIDTH + KCAP / 2;
    localparam int LAGW   = $clog2(LAGMAX + 1);
    localparam int NUM    = MAX_KERNEL * MAX_KERNEL;
    localparam int MIDW   = $clog2(NUM);

    typedef logic [MAX_KERNEL-1:0][PIX_W-1:0] t_col;

    t_cfg_w r_cfg_w;
    t_cfg_h r_cfg_h;
    t_cfg_k r_cfg_k;

    logic [WEW-1:0]  weff;
    t_cfg_h          heff;
    t_cfg_k          keff;
    logic [1:0]      hh;
    logic [LAGW-1:0] lag;
    logic [MIDW-1:0] mid;

    logic [CFG_H_W-1:0] r_in_row, n_in_row, r_out_row, n_out_row;
    logic [CW-1:0]      r_in_col, n_in_col, r_out_col, n_out_col;
    logic [LB-1:0]      r_in_line, n_in_line, r_out_line, n_out_line;
    logic [LAGW-1:0]    r_fill, n_fill;

    logic adv, acc, in_done, is_flush, pix_ok, cfg_wr;
    logic emit0, med0, last0, fwd0;

    t_col r_mem [MAX_WIDTH];
    t_col r_rd_col, r_rd_pass, col_w, newcol;
    logic [LB:0] lsum;

    logic          r_s1_shift, r_s1_emit, r_s1_med, r_s1_last, r_s1_fwd;
    t_pix          r_s1_pix;
    logic [LB-1:0] r_s1_line, r_s1_pline;
    logic          r_s2_emit, r_s2_med, r_s2_last;
    t_pix          r_s2_pass;
    logic          r_s3_emit, r_s3_med, r_s3_last;
    t_pix          r_s3_pass;
    logic          r_out_valid, r_out_last;
    t_pix          r_out_value;

    logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][PIX_W-1:0] r_win;
    logic [NUM-1:0][PIX_W-1:0] win_vals;
    logic [NUM-1:0]            win_mask;
    t_pix                      med_val;

    // effective frame geometry
    always_comb begin
        if (r_cfg_w == '0) begin
            weff = WEW'(1);
        end else if (int'(r_cfg_w) > MAX_WIDTH) begin
            weff = WEW'(MAX_WIDTH);
        end else begin
            weff = WEW'(r_cfg_w);
        end
        heff = (r_cfg_h == '0) ? t_cfg_h'(1) : r_cfg_h;
        keff = (int'(r_cfg_k) > MAX_KERNEL) ? '0 : r_cfg_k;
        hh   = keff[2:1];
        lag  = LAGW'(hh) * LAGW'(weff) + LAGW'(hh);
        mid  = MIDW'((int'(keff) * int'(keff)) >> 1);
    end

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
        && ((paddr[APB_AW-1:2] == REG_WIDTH) || (paddr[APB_AW-1:2] == REG_HEIGHT)
            || (paddr[APB_AW-1:2] == REG_KERNEL));

    always_comb begin
        case (paddr[APB_AW-1:2])
            REG_WIDTH:  prdata = APB_DW'(r_cfg_w);
            REG_HEIGHT: prdata = APB_DW'(r_cfg_h);
            REG_KERNEL: prdata = APB_DW'(r_cfg_k);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= RST_WIDTH;
            r_cfg_h <= RST_HEIGHT;
            r_cfg_k <= RST_KERNEL;
        end else if (psel && penable && pwrite) begin
            case (paddr[APB_AW-1:2])
                REG_WIDTH:  r_cfg_w <= pwdata[CFG_W_W-1:0];
                REG_HEIGHT: r_cfg_h <= pwdata[CFG_H_W-1:0];
                REG_KERNEL: r_cfg_k <= pwdata[CFG_K_W-1:0];
                default:    r_cfg_k <= r_cfg_k;
            endcase
        end
    end

    // input side decisions
    assign adv      = !r_out_valid || o_out.ready;
    assign acc      = i_in.valid && adv;
    assign in_done  = r_in_row >= heff;
    assign is_flush = i_in.req_type == REQ_FLUSH;
    assign pix_ok   = acc && !is_flush && !in_done;
    assign emit0    = acc && (is_flush ? in_done : (!in_done && (r_fill == lag)));
    assign fwd0     = pix_ok && (r_out_col == r_in_col) && (r_out_line == r_in_line);

    always_comb begin
        med0 = keff[0] && (keff > 3'd1)
            && (r_out_row >= CFG_H_W'(hh))
            && (({1'b0, r_out_row} + (CFG_H_W+1)'(hh)) < {1'b0, heff})
            && (r_out_col >= CW'(hh))
            && ((WEW'(r_out_col) + WEW'(hh)) < weff);
        last0 = (({1'b0, r_out_row} + (CFG_H_W+1)'(1)) >= {1'b0, heff})
             && ((WEW'(r_out_col) + WEW'(1)) >= weff);
    end

    // raster position counters
    always_comb begin
        n_in_row   = r_in_row;
        n_in_col   = r_in_col;
        n_in_line  = r_in_line;
        n_out_row  = r_out_row;
        n_out_col  = r_out_col;
        n_out_line = r_out_line;
        n_fill     = r_fill;
        if (pix_ok) begin
            if (r_fill != lag) begin
                n_fill = r_fill + 1'b1;
            end
            if ((WEW'(r_in_col) + WEW'(1)) >= weff) begin
                n_in_col  = '0;
                n_in_row  = r_in_row + 1'b1;
                n_in_line = (r_in_line == LB'(MAX_KERNEL - 1)) ? '0 : r_in_line + 1'b1;
            end else begin
                n_in_col = r_in_col + 1'b1;
            end
        end
        if (emit0) begin
            if ((WEW'(r_out_col) + WEW'(1)) >= weff) begin
                n_out_col  = '0;
                n_out_row  = r_out_row + 1'b1;
                n_out_line = (r_out_line == LB'(MAX_KERNEL - 1)) ? '0 : r_out_line + 1'b1;
            end else begin
                n_out_col = r_out_col + 1'b1;
            end
        end
        if ((emit0 && last0) || cfg_wr) begin
            n_in_row   = '0;
            n_in_col   = '0;
            n_in_line  = '0;
            n_out_row  = '0;
            n_out_col  = '0;
            n_out_line = '0;
            n_fill     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_in_line  <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_out_line <= '0;
            r_fill     <= '0;
        end else begin
            r_in_row   <= n_in_row;
            r_in_col   <= n_in_col;
            r_in_line  <= n_in_line;
            r_out_row  <= n_out_row;
            r_out_col  <= n_out_col;
            r_out_line <= n_out_line;
            r_fill     <= n_fill;
        end
    end

    // line store: one word per column, one lane per line buffer
    always_ff @(posedge i_clk) begin
        if (pix_ok) begin
            r_mem[r_in_col][r_in_line] <= i_in.pixel_value;
        end
        if (adv) begin
            r_rd_col  <= r_mem[r_in_col];
            r_rd_pass <= r_mem[r_out_col];
        end
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_shift  <= 1'b0;
            r_s1_emit   <= 1'b0;
            r_s2_emit   <= 1'b0;
            r_s3_emit   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_shift  <= pix_ok;
            r_s1_emit   <= emit0;
            r_s2_emit   <= r_s1_emit;
            r_s3_emit   <= r_s2_emit;
            r_out_valid <= r_s3_emit;
        end
    end

    // column of the newest pixel, ordered from current row upward
    always_comb begin
        col_w            = r_rd_col;
        col_w[r_s1_line] = r_s1_pix;
        lsum             = '0;
        newcol           = '0;
        for (int d = 0; d < MAX_KERNEL; d++) begin
            lsum = (LB+1)'(int'(r_s1_line) + MAX_KERNEL - d);
            if (lsum >= (LB+1)'(MAX_KERNEL)) begin
                lsum = lsum - (LB+1)'(MAX_KERNEL);
            end
            newcol[d] = col_w[lsum[LB-1:0]];
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_med   <= med0;
            r_s1_last  <= last0;
            r_s1_fwd   <= fwd0;
            r_s1_pix   <= i_in.pixel_value;
            r_s1_line  <= r_in_line;
            r_s1_pline <= r_out_line;

            if (r_s1_shift) begin
                r_win[0] <= newcol;
                for (int a = 1; a < MAX_KERNEL; a++) begin
                    r_win[a] <= r_win[a-1];
                end
            end
            r_s2_med  <= r_s1_med;
            r_s2_last <= r_s1_last;
            r_s2_pass <= r_s1_fwd ? r_s1_pix : r_rd_pass[r_s1_pline];

            r_s3_med  <= r_s2_med;
            r_s3_last <= r_s2_last;
            r_s3_pass <= r_s2_pass;

            r_out_value <= r_s3_med ? med_val : r_s3_pass;
            r_out_last  <= r_s3_last;
        end
    end

    // window taps inside the kernel
    always_comb begin
        for (int a = 0; a < MAX_KERNEL; a++) begin
            for (int d = 0; d < MAX_KERNEL; d++) begin
                win_vals[a*MAX_KERNEL+d] = r_win[a][d];
                win_mask[a*MAX_KERNEL+d] = (a < int'(keff)) && (d < int'(keff));
            end
        end
    end

    mfg_median #(
        .NUM  (NUM),
        .MIDW (MIDW)
    ) u_median (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_vals (win_vals),
        .i_mask (win_mask),
        .i_mid  (mid),
        .o_med  (med_val)
    );

    assign i_in.ready        = adv;
    assign o_out.valid       = r_out_valid;
    assign o_out.out_value   = r_out_value;
    assign o_out.frame_last  = r_out_last;

    a_in_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WEW'(r_in_col) < weff)
        else $error("input column beyond frame width");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= lag)
        else $error("fill count beyond lag");

    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit0 && last0) |=> (r_in_row == '0) && (r_out_row == '0) && (r_fill == '0))
        else $error("frame end did not restart counters");

endmodule
